// ===== src/ras_pkg.sv =====
// ----------------------------------------------------------------------------
// ras_pkg
// Shared constants, types and helpers for the resizing array stack.
// ----------------------------------------------------------------------------
package ras_pkg;

  // storage geometry
  localparam int DEPTH     = 128;
  localparam int WORD_BITS = 32;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // external field widths
  localparam int CFG_W = 8;
  localparam int OUT_W = 8;

  // capacity loaded at reset
  localparam int CAP_RESET_RAW = 10;
  localparam int CAP_RESET     = (CAP_RESET_RAW > DEPTH) ? DEPTH : CAP_RESET_RAW;
  // a full stack may double only while its capacity is at most this
  localparam int CAP_GROW_MAX  = DEPTH / 2;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } ras_action_e;

  typedef enum logic [1:0] {
    RS_NONE   = 2'd0,
    RS_DOUBLE = 2'd1,
    RS_HALVE  = 2'd2
  } ras_resize_e;

  // memory access issued by the controller
  typedef struct packed {
    logic                 we;
    logic                 re;
    logic [ADDR_W-1:0]    addr;
    logic [WORD_BITS-1:0] wdata;
  } ras_mem_req_t;

  // status of one operation, carried to the output stage
  typedef struct packed {
    logic             mem_read;
    logic             empty_error;
    logic             overflow_refused;
    ras_resize_e      resize_event;
    logic [CNT_W-1:0] capacity;
    logic [CNT_W-1:0] count;
  } ras_step_t;

  // clamp a written capacity into 1..DEPTH
  function automatic logic [CNT_W-1:0] clamp_cap(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (int'(v) > DEPTH) begin
      r = CNT_W'(DEPTH);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== src/ras_mem.sv =====
// ----------------------------------------------------------------------------
// ras_mem
// Entry storage: one write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module ras_mem (
  input  logic                          clk_i,
  input  ras_pkg::ras_mem_req_t         req_i,
  output logic [ras_pkg::WORD_BITS-1:0] rdata_o
);
  import ras_pkg::*;

  logic [WORD_BITS-1:0] mem_q [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ras_ctrl.sv =====
// ----------------------------------------------------------------------------
// ras_ctrl
// Count and capacity bookkeeping: decides each push or pop, updates the
// state and issues the memory access.
// ----------------------------------------------------------------------------
module ras_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          action_i,
  input  logic [ras_pkg::WORD_BITS-1:0] push_value_i,
  input  logic                          cfg_we_i,
  input  logic [ras_pkg::CFG_W-1:0]     cfg_wdata_i,
  output ras_pkg::ras_mem_req_t         mem_req_o,
  output ras_pkg::ras_step_t            step_o
);
  import ras_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] cap_q, cap_d;
  logic [CNT_W-1:0] half;
  logic             full;
  logic             is_pop;
  ras_step_t        step;
  ras_mem_req_t     req;

  assign is_pop = (action_i == ACT_POP);
  assign full   = (count_q >= cap_q);
  assign half   = cap_q >> 1;

  // decide the operation
  always_comb begin
    count_d               = count_q;
    cap_d                 = cap_q;
    req.we                = 1'b0;
    req.re                = 1'b0;
    req.addr              = count_q[ADDR_W-1:0];
    req.wdata             = push_value_i;
    step.mem_read         = 1'b0;
    step.empty_error      = 1'b0;
    step.overflow_refused = 1'b0;
    step.resize_event     = RS_NONE;
    if (!is_pop) begin
      if ((int'(count_q) >= DEPTH) || (full && (int'(cap_q) > CAP_GROW_MAX))) begin
        step.overflow_refused = 1'b1;
      end else begin
        if (full) begin
          cap_d             = cap_q << 1;
          step.resize_event = RS_DOUBLE;
        end
        req.we  = accept_i;
        count_d = count_q + CNT_W'(1);
      end
    end else begin
      // halving check comes before the empty check
      if ((half != '0) && ((half - CNT_W'(1)) == count_q)) begin
        cap_d             = half;
        step.resize_event = RS_HALVE;
      end
      if (count_q == '0) begin
        step.empty_error = 1'b1;
      end else begin
        count_d       = count_q - CNT_W'(1);
        req.addr      = count_d[ADDR_W-1:0];
        req.re        = accept_i;
        step.mem_read = 1'b1;
      end
    end
    step.capacity = cap_d;
    step.count    = count_d;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= CNT_W'(CAP_RESET);
    end else if (cfg_we_i) begin
      cap_q <= clamp_cap(cfg_wdata_i);
    end else if (accept_i) begin
      count_q <= count_d;
      cap_q   <= cap_d;
    end
  end

  assign mem_req_o = req;
  assign step_o    = step;

  // count stays within storage
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= DEPTH)
    else $error("entry count above storage depth");

  // capacity never drops to zero
  a_cap_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_q != '0)
    else $error("capacity reached zero");

  // a refused push leaves the count alone
  a_refuse_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !cfg_we_i && step.overflow_refused) |=> $stable(count_q))
    else $error("refused push changed the count");

  // a read is issued only for a nonempty pop
  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.re |-> (is_pop && (count_q != '0)))
    else $error("memory read on empty stack");

endmodule

// ===== src/resizing_array_stack.sv =====
// ----------------------------------------------------------------------------
// resizing_array_stack
// LIFO stack of words with a logical capacity that doubles on a full push and
// halves on a pop at half capacity less one, over a fixed synchronous memory.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+----------------------------
//  in       | input     | in_valid_i / in_stall_o  | action, push_value
//  out      | output    | out_valid_o / out_stall_i| pop_value, flags, capacity,
//           |           |                          | item_count
//  cfg      | input     | cfg_we_i                 | cfg_wdata_i (initial_capacity)
//
// One word per cycle sustained while the output is not stalled; a result passes
// through the memory read, then the output register, after its word is taken.
// The memory's single port and registered read set the two-stage path.
// Reset clears the count and loads capacity 10; the memory is not cleared.
// A stalled output holds its word; the input stalls only when the pending
// stage cannot move into a full output register.
module resizing_array_stack (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [ras_pkg::WORD_BITS-1:0] push_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ras_pkg::WORD_BITS-1:0] pop_value_o,
  output logic                          empty_error_o,
  output logic                          overflow_refused_o,
  output logic [1:0]                    resize_event_o,
  output logic [ras_pkg::OUT_W-1:0]     current_capacity_o,
  output logic [ras_pkg::OUT_W-1:0]     item_count_o,
  input  logic                          cfg_we_i,
  input  logic [ras_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import ras_pkg::*;

  logic                 accept;
  logic                 out_free;
  logic                 pend_move;
  logic                 pend_q;
  ras_step_t            step;
  ras_step_t            step_q;
  ras_mem_req_t         mem_req;
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] pop_value_d;
  logic                 out_valid_q;
  logic [WORD_BITS-1:0] pop_value_q;
  logic                 empty_error_q;
  logic                 overflow_refused_q;
  logic [1:0]           resize_event_q;
  logic [OUT_W-1:0]     capacity_q;
  logic [OUT_W-1:0]     count_q;

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign pend_move  = pend_q && out_free;
  assign in_stall_o = pend_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  ras_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .action_i     (action_i),
    .push_value_i (push_value_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .mem_req_o    (mem_req),
    .step_o       (step)
  );

  ras_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // pending stage waits for the memory read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (accept) begin
      pend_q <= 1'b1;
    end else if (pend_move) begin
      pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      step_q <= step;
    end
  end

  // popped word, all ones on empty pop, zero for push
  always_comb begin
    if (step_q.mem_read) begin
      pop_value_d = rdata;
    end else if (step_q.empty_error) begin
      pop_value_d = '1;
    end else begin
      pop_value_d = '0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pend_move) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_move) begin
      pop_value_q        <= pop_value_d;
      empty_error_q      <= step_q.empty_error;
      overflow_refused_q <= step_q.overflow_refused;
      resize_event_q     <= step_q.resize_event;
      capacity_q         <= OUT_W'(step_q.capacity);
      count_q            <= OUT_W'(step_q.count);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign pop_value_o        = pop_value_q;
  assign empty_error_o      = empty_error_q;
  assign overflow_refused_o = overflow_refused_q;
  assign resize_event_o     = resize_event_q;
  assign current_capacity_o = capacity_q;
  assign item_count_o       = count_q;

  // a pending word that cannot move stays pending
  a_pend_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && !out_free) |=> pend_q)
    else $error("pending word lost");

  // input is never taken while the pending stage is blocked
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (!pend_q || out_free))
    else $error("word accepted over a blocked pending stage");

  // every pending word is loaded into the output register when it moves
  a_move_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_move |=> out_valid_q)
    else $error("pending word did not reach output");

endmodule

// ===== test/tb_resizing_array_stack.sv =====
// ----------------------------------------------------------------------------
// tb_resizing_array_stack
// Self-checking bench for the resizing array stack. A predictor keeps its own
// copy of the entries, count and logical capacity, works out one expected
// result per accepted word, and compares each delivered result field by field
// in order. Covers directed corner words, then push- or pop-weighted random
// phases under several capacity settings, with random idling on both sides
// and one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_resizing_array_stack;
  timeunit 1ns;
  timeprecision 1ps;

  import ras_pkg::*;

  localparam int STORE_WORDS    = ras_pkg::DEPTH;
  localparam int RESET_CAPACITY = 10;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS    = 20;

  // one result word as seen on the output channel
  typedef struct packed {
    logic [ras_pkg::WORD_BITS-1:0] pop_value;
    logic                          empty_error;
    logic                          overflow_refused;
    ras_resize_e                   resize_event;
    logic [ras_pkg::OUT_W-1:0]     capacity;
    logic [ras_pkg::OUT_W-1:0]     count;
  } stack_result_t;

  // predicted stack state and the results still owed by the block
  class stack_tracker;
    logic [ras_pkg::WORD_BITS-1:0] words [STORE_WORDS];
    int unsigned                   fill;
    int unsigned                   cap;
    stack_result_t                 owed [$];
    int                            errors;

    function new();
      fill   = 0;
      cap    = RESET_CAPACITY;
      errors = 0;
    endfunction

    // capacity register write, clamped into 1..depth
    function void load_capacity(logic [ras_pkg::CFG_W-1:0] value);
      if (value == '0) begin
        cap = 1;
      end else if (int'(value) > STORE_WORDS) begin
        cap = STORE_WORDS;
      end else begin
        cap = value;
      end
    endfunction

    // apply one accepted word and queue the result it must produce
    function void apply_word(ras_action_e act, logic [ras_pkg::WORD_BITS-1:0] value);
      stack_result_t r;
      int unsigned   half;
      r = '0;
      r.resize_event = RS_NONE;
      if (act == ACT_PUSH) begin
        // refused when storage is exhausted or doubling would not fit
        if (fill >= STORE_WORDS || (fill >= cap && cap * 2 > STORE_WORDS)) begin
          r.overflow_refused = 1'b1;
        end else begin
          if (fill >= cap) begin
            cap = cap * 2;
            r.resize_event = RS_DOUBLE;
          end
          words[fill] = value;
          fill++;
        end
      end else begin
        // shrink check comes before the empty check
        half = cap / 2;
        if (half >= 1 && half - 1 == fill) begin
          cap = half;
          r.resize_event = RS_HALVE;
        end
        if (fill == 0) begin
          r.pop_value   = '1;
          r.empty_error = 1'b1;
        end else begin
          fill--;
          r.pop_value = words[fill];
        end
      end
      r.capacity = ras_pkg::OUT_W'(cap);
      r.count    = ras_pkg::OUT_W'(fill);
      owed.push_back(r);
    endfunction

    function int pending();
      return owed.size();
    endfunction

    task report(string msg);
      if (errors < MAX_REPORTS) begin
        $display("mismatch at %0t: %s", $realtime, msg);
      end
      errors++;
    endtask

    // compare a delivered result with the oldest owed one
    task check_result(stack_result_t got);
      stack_result_t want;
      if (owed.size() == 0) begin
        report($sformatf("result with nothing owed, pop_value %h", got.pop_value));
        return;
      end
      want = owed.pop_front();
      if (got.pop_value !== want.pop_value) begin
        report($sformatf("pop_value got %h want %h", got.pop_value, want.pop_value));
      end
      if (got.empty_error !== want.empty_error) begin
        report($sformatf("empty_error got %b want %b", got.empty_error, want.empty_error));
      end
      if (got.overflow_refused !== want.overflow_refused) begin
        report($sformatf("overflow_refused got %b want %b",
                         got.overflow_refused, want.overflow_refused));
      end
      if (got.resize_event !== want.resize_event) begin
        report($sformatf("resize_event got %0d want %0d",
                         got.resize_event, want.resize_event));
      end
      if (got.capacity !== want.capacity) begin
        report($sformatf("capacity got %0d want %0d", got.capacity, want.capacity));
      end
      if (got.count !== want.count) begin
        report($sformatf("item_count got %0d want %0d", got.count, want.count));
      end
    endtask
  endclass

  logic                          clk;
  logic                          rst_n      = 1'b0;
  logic                          in_valid   = 1'b0;
  logic                          in_stall;
  logic                          action     = 1'b0;
  logic [ras_pkg::WORD_BITS-1:0] push_value = '0;
  logic                          out_valid;
  logic                          out_stall  = 1'b0;
  logic [ras_pkg::WORD_BITS-1:0] pop_value;
  logic                          empty_error;
  logic                          overflow_refused;
  logic [1:0]                    resize_event;
  logic [ras_pkg::OUT_W-1:0]     current_capacity;
  logic [ras_pkg::OUT_W-1:0]     item_count;
  logic                          cfg_we     = 1'b0;
  logic [ras_pkg::CFG_W-1:0]     cfg_wdata  = '0;

  stack_tracker  sb;
  stack_result_t seen;
  bit            idle_on  = 1'b1;
  bit            hold_req = 1'b0;
  int            quiet_cycles;

  resizing_array_stack dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .action_i           (action),
    .push_value_i       (push_value),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .pop_value_o        (pop_value),
    .empty_error_o      (empty_error),
    .overflow_refused_o (overflow_refused),
    .resize_event_o     (resize_event),
    .current_capacity_o (current_capacity),
    .item_count_o       (item_count),
    .cfg_we_i           (cfg_we),
    .cfg_wdata_i        (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // random word, with the extremes mixed in
  function automatic logic [ras_pkg::WORD_BITS-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // offer one word, optionally after an idle burst, and wait for acceptance
  task automatic send_word(input ras_action_e act, input logic [ras_pkg::WORD_BITS-1:0] value);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    push_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.apply_word(act, value);
  endtask

  // write the capacity register once the block has gone quiet
  task automatic set_capacity(input logic [ras_pkg::CFG_W-1:0] value);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.load_capacity(value);
  endtask

  // one random phase: capacity setting, then random words weighted by push_pct
  task automatic run_phase(input logic [ras_pkg::CFG_W-1:0] cap_value, input int words,
                           input int push_pct, input bit long_hold);
    set_capacity(cap_value);
    hold_req = long_hold;
    for (int i = 0; i < words; i++) begin
      if ($urandom_range(0, 99) < push_pct) begin
        send_word(ACT_PUSH, random_word());
      end else begin
        send_word(ACT_POP, random_word());
      end
    end
  endtask

  // output side stalls, including the one long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // result checking on every accepted output word
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen.pop_value        = pop_value;
      seen.empty_error      = empty_error;
      seen.overflow_refused = overflow_refused;
      seen.resize_event     = ras_resize_e'(resize_event);
      seen.capacity         = current_capacity;
      seen.count            = item_count;
      sb.check_result(seen);
    end
  end

  // watchdog on cycles with no word moving on either channel
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("[resizing_array_stack] ERROR");
    $finish;
  end

  // stimulus
  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset capacity: empty pop, extreme pushes, drain through two halvings
    send_word(ACT_POP, 32'h1234_5678);
    send_word(ACT_PUSH, 32'h7FFF_FFFF);
    send_word(ACT_PUSH, 32'h8000_0000);
    send_word(ACT_PUSH, 32'h0000_0000);
    send_word(ACT_PUSH, 32'hFFFF_FFFF);
    send_word(ACT_PUSH, 32'h5555_5555);
    send_word(ACT_PUSH, 32'hAAAA_AAAA);
    repeat (6) send_word(ACT_POP, 32'hFFFF_FFFF);
    // halving on an empty pop
    send_word(ACT_POP, 32'h0000_0000);
    // growth from capacity one
    repeat (3) send_word(ACT_PUSH, random_word());

    // zero loads one, count now above capacity
    set_capacity(8'd0);
    send_word(ACT_PUSH, 32'h0F0F_0F0F);
    send_word(ACT_POP, 32'h0);
    // above depth loads depth
    set_capacity(8'd255);
    send_word(ACT_POP, 32'h0);
    send_word(ACT_PUSH, 32'hF0F0_F0F0);

    // random phases: grow, push past depth under a long hold-off, drain
    run_phase(8'd1,   40, 70, 1'b0);
    run_phase(8'd128, 160, 92, 1'b1);
    run_phase(8'd65,  40, 40, 1'b0);
    run_phase(8'd3,   40, 20, 1'b0);
    run_phase(8'd255, 30, 50, 1'b0);
    run_phase(8'd0,   30, 30, 1'b0);
    idle_on = 1'b0;
    run_phase(ras_pkg::CFG_W'($urandom_range(1, 255)), 40, 55, 1'b0);

    // wait for the last results, then let the block drain quietly
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[resizing_array_stack] OK");
    end else begin
      $display("[resizing_array_stack] ERROR");
    end
    $finish;
  end

endmodule

// ===== resizing_array_stack.f =====
src/ras_pkg.sv
src/ras_mem.sv
src/ras_ctrl.sv
src/resizing_array_stack.sv
test/tb_resizing_array_stack.sv
